FILE: sv/msplm_pkg.sv
package msplm_pkg;

	// sample width; the port fields are 16 bits wide
	localparam int SAMPLE_BITS    = 16;
	localparam int PEAK_BITS      = SAMPLE_BITS + 1;
	localparam int LOG_TABLE_BITS = 6;
	localparam int TAB_SIZE       = 1 << LOG_TABLE_BITS;
	localparam int EXP_BITS       = $clog2(PEAK_BITS);
	localparam int LG_BITS        = EXP_BITS + 16;
	localparam int DIFF_BITS      = LG_BITS + 1;
	localparam int PROD_BITS      = DIFF_BITS + 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic signed [PEAK_BITS-1:0] HIGH_RESET = {1'b1, {SAMPLE_BITS{1'b0}}};
	localparam logic signed [PEAK_BITS-1:0] LOW_RESET  = {1'b0, {SAMPLE_BITS{1'b1}}};

	localparam logic signed [15:0] DB_FLOOR = 16'sh8000;

	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic               block_last;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] mid_level_db;
		logic signed [15:0] side_level_db;
		logic               mid_silent;
		logic               side_silent;
	} level_t;

	typedef struct packed {
		logic signed [PEAK_BITS-1:0] high;
		logic signed [PEAK_BITS-1:0] low;
	} peak_t;

	typedef struct packed {
		peak_t mid;
		peak_t side;
	} snap_t;

	typedef struct packed {
		logic  valid;
		snap_t snap;
	} push_t;

	typedef logic [15:0] frac_tab_t [TAB_SIZE];

	// log2(1 + i/TAB_SIZE) in Q16 by repeated squaring in Q30
	function automatic frac_tab_t build_frac_tab();
		frac_tab_t   tab;
		logic [63:0] y;
		logic [15:0] r;
		for (int i = 0; i < TAB_SIZE; i++) begin
			y = 64'(TAB_SIZE + i) << (30 - LOG_TABLE_BITS);
			r = '0;
			for (int k = 0; k < 16; k++) begin
				y = (y * y) >> 30;
				r = {r[14:0], 1'b0};
				if (y >= (64'd2 << 30)) begin
					y    = y >> 1;
					r[0] = 1'b1;
				end
			end
			tab[i] = r;
		end
		return tab;
	endfunction

	localparam frac_tab_t FRAC_TAB = build_frac_tab();

	// log of the full-scale references: 2^SAMPLE_BITS-2 and 2^SAMPLE_BITS
	localparam logic [LG_BITS-1:0] LG_REF_MAX =
		LG_BITS'((SAMPLE_BITS - 1) * 65536 + int'(FRAC_TAB[TAB_SIZE-1]));
	localparam logic [LG_BITS-1:0] LG_REF_MIN = LG_BITS'(SAMPLE_BITS * 65536);

endpackage

FILE: sv/msplm_front.sv
module msplm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	input  msplm_pkg::sample_t sample,
	input  logic              queue_full,
	output logic              sample_stall,
	output msplm_pkg::push_t  push
);

	logic signed [msplm_pkg::PEAK_BITS-1:0] mid_high_q, mid_low_q;
	logic signed [msplm_pkg::PEAK_BITS-1:0] side_high_q, side_low_q;
	logic signed [msplm_pkg::PEAK_BITS-1:0] left_x, right_x, mid, side;
	msplm_pkg::snap_t                       next_snap;
	logic                                   accept;

	assign sample_stall = queue_full;
	assign accept       = sample_valid && !queue_full;

	assign left_x  = {sample.left_sample[msplm_pkg::SAMPLE_BITS-1],
		sample.left_sample[msplm_pkg::SAMPLE_BITS-1:0]};
	assign right_x = {sample.right_sample[msplm_pkg::SAMPLE_BITS-1],
		sample.right_sample[msplm_pkg::SAMPLE_BITS-1:0]};
	assign mid     = left_x + right_x;
	assign side    = right_x - left_x;

	always_comb begin
		next_snap.mid.high  = (mid > mid_high_q)   ? mid  : mid_high_q;
		next_snap.mid.low   = (mid < mid_low_q)    ? mid  : mid_low_q;
		next_snap.side.high = (side > side_high_q) ? side : side_high_q;
		next_snap.side.low  = (side < side_low_q)  ? side : side_low_q;
	end

	assign push.valid = accept && sample.block_last;
	assign push.snap  = next_snap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_high_q  <= msplm_pkg::HIGH_RESET;
			mid_low_q   <= msplm_pkg::LOW_RESET;
			side_high_q <= msplm_pkg::HIGH_RESET;
			side_low_q  <= msplm_pkg::LOW_RESET;
		end else if (accept) begin
			if (sample.block_last) begin
				mid_high_q  <= msplm_pkg::HIGH_RESET;
				mid_low_q   <= msplm_pkg::LOW_RESET;
				side_high_q <= msplm_pkg::HIGH_RESET;
				side_low_q  <= msplm_pkg::LOW_RESET;
			end else begin
				mid_high_q  <= next_snap.mid.high;
				mid_low_q   <= next_snap.mid.low;
				side_high_q <= next_snap.side.high;
				side_low_q  <= next_snap.side.low;
			end
		end
	end

endmodule

FILE: sv/msplm_queue.sv
module msplm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  msplm_pkg::push_t push,
	input  logic             pop,
	output logic             full,
	output logic             nonempty,
	output msplm_pkg::snap_t head
);

	msplm_pkg::snap_t                  entry_q [msplm_pkg::QUEUE_DEPTH];
	logic [msplm_pkg::QUEUE_AW-1:0]    rd_ptr_q, wr_ptr_q;
	logic [msplm_pkg::QUEUE_AW:0]      count_q;
	logic                              do_pop;

	assign full     = (count_q == (msplm_pkg::QUEUE_AW+1)'(msplm_pkg::QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = entry_q[rd_ptr_q];
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.snap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push.valid, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: sv/msplm_back.sv
module msplm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              queue_nonempty,
	input  msplm_pkg::snap_t  queue_head,
	output logic              queue_pop,
	output logic              level_valid,
	input  logic              level_stall,
	output msplm_pkg::level_t level
);

	localparam int PB = msplm_pkg::PEAK_BITS;
	localparam int SB = msplm_pkg::SAMPLE_BITS;
	localparam int LT = msplm_pkg::LOG_TABLE_BITS;

	// lane 0 is mid, lane 1 is side
	msplm_pkg::peak_t   peak [2];
	logic [PB-1:0]      mag_a [2];
	logic [PB-1:0]      mag_b [2];
	logic [PB-1:0]      gap [2];
	logic               pick_a [2];
	logic               quiet [2];

	logic               v_s1, v_s2, level_valid_q;
	logic [PB-1:0]      x_s1 [2];
	logic               pick_a_s1 [2];
	logic               quiet_s1 [2];

	logic [msplm_pkg::EXP_BITS-1:0] lead [2];
	logic [PB+LT-1:0]               spread [2];
	logic [msplm_pkg::EXP_BITS-1:0] exp_s2 [2];
	logic [LT-1:0]                  idx_s2 [2];
	logic                           pick_a_s2 [2];
	logic                           quiet_s2 [2];

	logic [msplm_pkg::LG_BITS-1:0]          lg [2];
	logic signed [msplm_pkg::DIFF_BITS-1:0] diff [2];
	logic signed [msplm_pkg::PROD_BITS-1:0] prod [2];
	logic signed [15:0]                     db [2];
	msplm_pkg::level_t                      level_q;

	logic en_out, en_s2, en_s1;

	assign en_out    = !level_valid_q || !level_stall;
	assign en_s2     = !v_s2 || en_out;
	assign en_s1     = !v_s1 || en_s2;
	assign queue_pop = queue_nonempty && en_s1;

	assign peak[0] = queue_head.mid;
	assign peak[1] = queue_head.side;

	// stage 1: magnitudes and choice of candidate, exact compare of a/(2^n-2) vs b/2^n
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			mag_a[l] = peak[l].high[PB-1] ? '0 : peak[l].high;
			mag_b[l] = peak[l].low[PB-1] ? PB'(-peak[l].low) : '0;
			gap[l]   = mag_b[l] - mag_a[l];
			quiet[l] = (mag_a[l] == '0) && (mag_b[l] == '0);
			if (mag_a[l] == '0) begin
				pick_a[l] = 1'b0;
			end else if ((mag_b[l] == '0) || (mag_a[l] >= mag_b[l])) begin
				pick_a[l] = 1'b1;
			end else begin
				pick_a[l] = ((gap[l] == PB'(1)) && mag_b[l][SB-1] == 1'b1)
					|| ((gap[l] == PB'(2)) && mag_b[l][SB] == 1'b1)
					|| ((gap[l] == PB'(1)) && mag_b[l][SB] == 1'b1);
			end
		end
	end

	// stage 2: leading one and the table index below it
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			lead[l] = '0;
			for (int k = 0; k < PB; k++) begin
				if (x_s1[l][k]) begin
					lead[l] = msplm_pkg::EXP_BITS'(k);
				end
			end
			spread[l] = {x_s1[l], {LT{1'b0}}} >> lead[l];
		end
	end

	// stage 3: log, reference subtract, scale by 6 and round half up
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			lg[l]   = {exp_s2[l], 16'b0} + msplm_pkg::LG_BITS'(msplm_pkg::FRAC_TAB[idx_s2[l]]);
			diff[l] = $signed({1'b0, lg[l]})
				- $signed({1'b0, pick_a_s2[l] ? msplm_pkg::LG_REF_MAX
					: msplm_pkg::LG_REF_MIN});
			prod[l] = (msplm_pkg::PROD_BITS'(diff[l]) <<< 2)
				+ (msplm_pkg::PROD_BITS'(diff[l]) <<< 1)
				+ msplm_pkg::PROD_BITS'(128);
			// the level never exceeds full scale, so the result needs no clamp
			db[l]   = quiet_s2[l] ? msplm_pkg::DB_FLOOR : prod[l][23:8];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int l = 0; l < 2; l++) begin
				x_s1[l]      <= pick_a[l] ? mag_a[l] : mag_b[l];
				pick_a_s1[l] <= pick_a[l];
				quiet_s1[l]  <= quiet[l];
			end
		end
		if (en_s2) begin
			for (int l = 0; l < 2; l++) begin
				exp_s2[l]    <= lead[l];
				idx_s2[l]    <= spread[l][LT-1:0];
				pick_a_s2[l] <= pick_a_s1[l];
				quiet_s2[l]  <= quiet_s1[l];
			end
		end
		if (en_out && v_s2) begin
			level_q.mid_level_db  <= db[0];
			level_q.side_level_db <= db[1];
			level_q.mid_silent    <= quiet_s2[0];
			level_q.side_silent   <= quiet_s2[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			level_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= queue_nonempty;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_out) begin
				level_valid_q <= v_s2;
			end
		end
	end

	assign level_valid = level_valid_q;
	assign level       = level_q;

endmodule

FILE: sv/mid_side_peak_level_meter_top.sv
// mid/side peak level meter: takes one signed stereo sample pair per cycle, forms
// mid = L+R and side = R-L (exact, half-lsb units) and tracks the min and max of
// each; on the pair flagged block_last it emits one item with 6*log2(peak level)
// in signed q7.8 db for mid and side, where 0 db is full scale and silence gives
// -32768 with the matching silent flag set; then the trackers start over. the
// front takes a pair every cycle and stalls only while four finished block
// snapshots wait in the queue; the back works one snapshot per cycle unless
// level_stall holds its output, through a three-stage log pipeline; a snapshot
// passes the queue and the stage-1, stage-2 and output registers to level_valid.
module mid_side_peak_level_meter_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  msplm_pkg::sample_t sample,
	output logic               level_valid,
	input  logic               level_stall,
	output msplm_pkg::level_t  level
);

	// end-of-block snapshot handed from front to back
	msplm_pkg::push_t push;
	msplm_pkg::snap_t queue_head;
	logic             queue_full;
	logic             queue_nonempty;
	logic             queue_pop;

	// front: running min/max trackers
	msplm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample       (sample),
		.queue_full   (queue_full),
		.sample_stall (sample_stall),
		.push         (push)
	);

	// short queue of pending block snapshots
	msplm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (queue_pop),
		.full     (queue_full),
		.nonempty (queue_nonempty),
		.head     (queue_head)
	);

	// back: level to db conversion, output register
	msplm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.queue_nonempty (queue_nonempty),
		.queue_head     (queue_head),
		.queue_pop      (queue_pop),
		.level_valid    (level_valid),
		.level_stall    (level_stall),
		.level          (level)
	);

endmodule
